>>> hw/rtl/fqrk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrk_pkg
// Shared widths, command and status codes and the cell-to-cell wave type of the
// remove-by-key queue.
// ----------------------------------------------------------------------------
package fqrk_pkg;

    localparam int PID_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_REMOVE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // search wave handed from one cell to the next, one cell per cycle
    typedef struct packed {
        logic tok;   // this cell evaluates in the current cycle
        logic gone;  // a match was found at or ahead of the sender
    } t_wave;

endpackage

>>> hw/rtl/fqrk_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrk_cmd_if
// Command channel: one item carries a command and a pid.
// ----------------------------------------------------------------------------
interface fqrk_cmd_if import fqrk_pkg::*;;
    logic             valid;
    logic             ready;
    logic             command;
    logic [PID_W-1:0] pid;

    modport source (output valid, output command, output pid, input ready);
    modport sink   (input valid, input command, input pid, output ready);
endinterface

>>> hw/rtl/fqrk_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrk_res_if
// Result channel: status, count and head entry after each command.
// ----------------------------------------------------------------------------
interface fqrk_res_if import fqrk_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                head_valid;
    logic [PID_W-1:0]    head_pid;

    modport source (output valid, output status, output count, output head_valid,
                    output head_pid, input ready);
    modport sink   (input valid, input status, input count, input head_valid,
                    input head_pid, output ready);
endinterface

>>> hw/rtl/fqrk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrk_cell
// One queue slot. Compares its entry with the key when the wave reaches it
// and, once a match lies at or ahead of it, pulls in its neighbor's entry.
// ----------------------------------------------------------------------------
module fqrk_cell import fqrk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wave            i_wave,
    output t_wave            o_wave,
    input  logic [PID_W-1:0] i_key,
    input  logic             i_occupied,
    input  logic             i_wr,
    input  logic [PID_W-1:0] i_next_pid,
    output logic [PID_W-1:0] o_pid
);

    logic             r_tok;
    logic             r_gone;
    logic [PID_W-1:0] r_pid;
    logic             n_gone;

    assign n_gone = i_wave.gone | (i_occupied & (r_pid == i_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_gone <= 1'b0;
        end else begin
            r_tok <= i_wave.tok;
            if (i_wave.tok) begin
                r_gone <= n_gone;
            end
        end
    end

    // the neighbor behind has not been touched yet when the wave is here
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_pid <= i_key;
        end else if (i_wave.tok && n_gone) begin
            r_pid <= i_next_pid;
        end
    end

    assign o_wave = '{tok: r_tok, gone: r_gone};
    assign o_pid  = r_pid;

endmodule

>>> hw/rtl/fifo_queue_remove_by_key_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_remove_by_key_unit
// Bounded ordered pid queue with append and remove-first-match, built as a
// row of DEPTH cells with the head in cell 0.
//
//   channel   modport   item fields
//   i_cmd     sink      command, pid
//   o_res     source    status, count, head_valid, head_pid
//
// Enqueue, and remove on an empty queue: S_ENQ or S_REM, then S_FIN, which
// loads the result once the output is free. Remove otherwise: S_REM, S_SCAN,
// S_FIN; a wave walks the row one cell per cycle, comparing and closing the gap
// behind the first match. i_cmd.ready is high only while no command is in work;
// a held result does not block the next accept, only the next result.
// Reset clears the count and control; slot contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_remove_by_key_unit import fqrk_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqrk_cmd_if.sink    i_cmd,
    fqrk_res_if.source  o_res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_ENQ, S_REM, S_SCAN, S_FIN} t_state;

    t_state              r_state;
    logic [PID_W-1:0]    r_key;
    logic [CW-1:0]       r_count;
    logic [SW-1:0]       r_scan;
    t_status             r_status;
    logic                r_res_valid;
    logic [STATUS_W-1:0] r_res_status;
    logic [COUNT_W-1:0]  r_res_count;
    logic                r_res_hv;
    logic [PID_W-1:0]    r_res_head;

    t_wave               wave [0:DEPTH];
    logic [PID_W-1:0]    pid_arr [0:DEPTH-1];
    logic                enq_wr;
    logic                out_free;

    assign enq_wr   = (r_state == S_ENQ) && (r_count != CW'(DEPTH));
    assign out_free = !r_res_valid || o_res.ready;
    assign wave[0]  = '{tok: (r_state == S_REM) && (r_count != '0), gone: 1'b0};

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [PID_W-1:0] next_pid;
        if (gi == DEPTH - 1) begin : g_last
            assign next_pid = pid_arr[gi];
        end else begin : g_mid
            assign next_pid = pid_arr[gi+1];
        end

        fqrk_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wave     (wave[gi]),
            .o_wave     (wave[gi+1]),
            .i_key      (r_key),
            .i_occupied (CW'(gi) < r_count),
            .i_wr       (enq_wr && (r_count == CW'(gi))),
            .i_next_pid (next_pid),
            .o_pid      (pid_arr[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            // S_FIN loads the next result itself
            if (o_res.ready && (r_state != S_FIN)) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_key   <= i_cmd.pid;
                        r_state <= (i_cmd.command == CMD_REMOVE) ? S_REM : S_ENQ;
                    end
                end
                S_ENQ: begin
                    if (enq_wr) begin
                        r_count  <= r_count + 1'b1;
                        r_status <= ST_ENQUEUED;
                    end else begin
                        r_status <= ST_FULL;
                    end
                    r_state <= S_FIN;
                end
                S_REM: begin
                    if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_FIN;
                    end else begin
                        r_scan  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // the last cell's registered result is visible in the cycle after it evaluated
                    if (r_scan == SW'(DEPTH - 1)) begin
                        if (wave[DEPTH].gone) begin
                            r_count  <= r_count - 1'b1;
                            r_status <= ST_REMOVED;
                        end else begin
                            r_status <= ST_NOT_FOUND;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_res_valid  <= 1'b1;
                        r_res_status <= r_status;
                        r_res_count  <= COUNT_W'(r_count);
                        r_res_hv     <= (r_count != '0);
                        r_res_head   <= (r_count != '0) ? pid_arr[0] : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_res_valid;
    assign o_res.status     = r_res_status;
    assign o_res.count      = r_res_count;
    assign o_res.head_valid = r_res_hv;
    assign o_res.head_pid   = r_res_head;

endmodule

>>> hw/rtl/fqrk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrk_checker
// Port-level checks of the remove-by-key queue, bound to the top level.
// ----------------------------------------------------------------------------
module fqrk_checker import fqrk_pkg::*; #(
    parameter int DEPTH = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [COUNT_W-1:0]  i_count,
    input logic                i_head_valid,
    input logic [PID_W-1:0]    i_head_pid
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("result item dropped or changed while stalled");

    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_head_valid == (i_count != '0)))
        else $error("head_valid disagrees with count");

    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_head_valid |-> (i_head_pid == '0))
        else $error("head_pid not zero on empty queue");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_count == COUNT_W'(DEPTH)))
        else $error("full status with queue not full");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in work");

endmodule

bind fifo_queue_remove_by_key_unit fqrk_checker #(.DEPTH(DEPTH)) u_fqrk_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_count      (o_res.count),
    .i_head_valid (o_res.head_valid),
    .i_head_pid   (o_res.head_pid)
);
